// File: rtl/core/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit checker.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rau_pkg.sv
package rau_pkg;

    // working width of all arithmetic, beats are always 32 bits wide
    localparam int INT_WIDTH = 32;
    localparam int FIELD_W   = 32;
    localparam int KIND_W    = 3;

    // divider shift count
    localparam int DIV_KW    = $clog2(INT_WIDTH);

    // multiplier: one 16-bit digit of the second operand per cycle
    localparam int MUL_DIG   = 16;
    localparam int MUL_STEPS = (INT_WIDTH + MUL_DIG - 1) / MUL_DIG;
    localparam int MUL_BP    = MUL_STEPS * MUL_DIG;
    localparam int MUL_CW    = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

    typedef logic signed [INT_WIDTH-1:0] t_int;
    typedef logic [INT_WIDTH-1:0]        t_mag;
    typedef logic signed [FIELD_W-1:0]   t_field;
    typedef logic [KIND_W-1:0]           t_kind;

    // operation codes
    localparam t_kind KIND_ADD = 3'd0;
    localparam t_kind KIND_SUB = 3'd1;
    localparam t_kind KIND_MUL = 3'd2;
    localparam t_kind KIND_DIV = 3'd3;
    localparam t_kind KIND_EQ  = 3'd4;
    localparam t_kind KIND_LT  = 3'd5;

    typedef struct packed {
        logic start;
        t_int dividend;
        t_int divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_int quot;
        t_int rem;
    } t_div_rsp;

    typedef struct packed {
        logic start;
        t_int a;
        t_int b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_int prod;
    } t_mul_rsp;

    // sign-extend a beat field and wrap it to the working width
    function automatic t_int field_in(input t_field v);
        logic [63:0] e;
        e = 64'(v);
        return t_int'(e[INT_WIDTH-1:0]);
    endfunction

    // low 32 bits of a working value
    function automatic t_field field_out(input t_int v);
        logic [63:0] e;
        e = 64'(v);
        return t_field'(e[FIELD_W-1:0]);
    endfunction

    // magnitude as unsigned; the most negative value maps onto itself
    function automatic t_mag mag(input t_int v);
        return v[INT_WIDTH-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

endpackage

// File: rtl/core/rau_if.sv
// input beat: operation and two fractions
interface rau_in_if import rau_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_field a_numerator;
    t_field a_denominator;
    t_field b_numerator;
    t_field b_denominator;

    modport source (output valid, kind, a_numerator, a_denominator, b_numerator,
                    b_denominator, input ready);
    modport sink   (input valid, kind, a_numerator, a_denominator, b_numerator,
                    b_denominator, output ready);
endinterface

// output beat: reduced fraction or comparison flag
interface rau_out_if import rau_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field res_numerator;
    t_field res_denominator;
    logic   compare_true;

    modport source (output valid, res_numerator, res_denominator, compare_true,
                    input ready);
    modport sink   (input valid, res_numerator, res_denominator, compare_true,
                    output ready);
endinterface

// File: rtl/core/rational_arithmetic_unit.sv
// The time per item is data dependent: each Euclid step runs on the shared divider,
//   whose cost follows log2 of the quotient, and each product runs on the multiplier.
// Throughput: one item at a time; ready is low from acceptance until the
//   result is in the output register, which may still hold the previous beat.
// Reset: synchronous, active low; clears sequencer, unit and output valid.
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rau_in_if.sink  i_in,
    rau_out_if.source o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_GCD   = 4'd2;
    localparam logic [3:0] S_REM   = 4'd3;
    localparam logic [3:0] S_QN    = 4'd4;
    localparam logic [3:0] S_QD    = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_MWAIT = 4'd8;
    localparam logic [3:0] S_COMB  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    // which fraction the reduction is working on
    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_R = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic [1:0] r_pi, n_pi;
    t_kind      r_kind, n_kind;
    t_int       r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    t_int       r_rn, n_rn, r_rd, n_rd;
    t_int       r_x, n_x, r_y, n_y;
    t_int       r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    logic       r_cmp, n_cmp;
    logic       r_ovalid, n_ovalid;
    t_field     r_onum, n_onum, r_oden, n_oden;
    logic       r_ocmp, n_ocmp;

    t_div_req   div_req;
    t_div_rsp   div_rsp;
    t_mul_req   mul_req;
    t_mul_rsp   mul_rsp;

    t_int       cur_n, cur_d, sum_n;
    logic       is_arith, pi_last, in_acc;

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign is_arith    = r_kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
    assign pi_last     = (r_kind == KIND_MUL || r_kind == KIND_DIV) ? (r_pi == 2'd1)
                                                                    : (r_pi == 2'd2);

    // fraction under reduction
    always_comb begin
        case (r_sel)
            SEL_A:   begin cur_n = r_an; cur_d = r_ad; end
            SEL_B:   begin cur_n = r_bn; cur_d = r_bd; end
            default: begin cur_n = r_rn; cur_d = r_rd; end
        endcase
    end

    // numerator of the combined result
    always_comb begin
        case (r_kind)
            KIND_ADD: sum_n = r_p0 + r_p1;
            KIND_SUB: sum_n = r_p0 - r_p1;
            default:  sum_n = r_p0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_pi     = r_pi;
        n_kind   = r_kind;
        n_an     = r_an;
        n_ad     = r_ad;
        n_bn     = r_bn;
        n_bd     = r_bd;
        n_rn     = r_rn;
        n_rd     = r_rd;
        n_x      = r_x;
        n_y      = r_y;
        n_p0     = r_p0;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_cmp    = r_cmp;
        n_ovalid = r_ovalid;
        n_onum   = r_onum;
        n_oden   = r_oden;
        n_ocmp   = r_ocmp;

        div_req          = '0;
        div_req.dividend = r_x;
        div_req.divisor  = r_y;
        mul_req          = '0;
        mul_req.a        = r_ad;
        mul_req.b        = r_bd;

        // output beat taken
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind  = i_in.kind;
                    n_an    = field_in(i_in.a_numerator);
                    n_ad    = field_in(i_in.a_denominator);
                    n_bn    = field_in(i_in.b_numerator);
                    n_bd    = field_in(i_in.b_denominator);
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_cmp = 1'b0;
                n_rn  = '0;
                n_rd  = '0;
                if (!(is_arith || r_kind == KIND_EQ || r_kind == KIND_LT)) begin
                    n_state = S_FIN;
                end else if (r_ad == '0 || r_bd == '0) begin
                    // NaN operand: arithmetic passes it through, compares fail
                    if (is_arith) begin
                        n_rn = (r_ad == '0) ? r_an : r_bn;
                        n_rd = (r_ad == '0) ? r_ad : r_bd;
                    end
                    n_state = S_FIN;
                end else begin
                    n_sel   = SEL_A;
                    n_x     = r_an;
                    n_y     = r_ad;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_y != '0) begin
                    div_req.start = 1'b1;
                    n_state       = S_REM;
                end else if (r_x == '0) begin
                    // zero over zero stays zero over zero
                    case (r_sel)
                        SEL_A:   begin n_an = '0; n_ad = '0; end
                        SEL_B:   begin n_bn = '0; n_bd = '0; end
                        default: begin n_rn = '0; n_rd = '0; end
                    endcase
                    n_state = S_NEXT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cur_n;
                    div_req.divisor  = r_x;
                    n_state          = S_QN;
                end
            end
            S_REM: begin
                if (div_rsp.done) begin
                    n_x     = r_y;
                    n_y     = div_rsp.rem;
                    n_state = S_GCD;
                end
            end
            S_QN: begin
                if (div_rsp.done) begin
                    n_y              = div_rsp.quot;
                    div_req.start    = 1'b1;
                    div_req.dividend = cur_d;
                    div_req.divisor  = r_x;
                    n_state          = S_QD;
                end
            end
            S_QD: begin
                if (div_rsp.done) begin
                    case (r_sel)
                        SEL_A:   begin n_an = r_y; n_ad = div_rsp.quot; end
                        SEL_B:   begin n_bn = r_y; n_bd = div_rsp.quot; end
                        default: begin n_rn = r_y; n_rd = div_rsp.quot; end
                    endcase
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                case (r_sel)
                    SEL_A: begin
                        n_sel   = SEL_B;
                        n_x     = r_bn;
                        n_y     = r_bd;
                        n_state = S_GCD;
                    end
                    SEL_B: begin
                        n_pi    = 2'd0;
                        n_state = S_MUL;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_MUL: begin
                // operand pairs per product slot
                mul_req.start = 1'b1;
                case (r_pi)
                    2'd0: begin
                        mul_req.a = r_an;
                        mul_req.b = (r_kind == KIND_MUL) ? r_bn : r_bd;
                    end
                    2'd1: begin
                        mul_req.a = (r_kind == KIND_MUL || r_kind == KIND_DIV) ? r_ad : r_bn;
                        mul_req.b = (r_kind == KIND_MUL) ? r_bd
                                  : (r_kind == KIND_DIV) ? r_bn : r_ad;
                    end
                    default: begin
                        mul_req.a = r_ad;
                        mul_req.b = r_bd;
                    end
                endcase
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_rsp.done) begin
                    case (r_pi)
                        2'd0:    n_p0 = mul_rsp.prod;
                        2'd1:    n_p1 = mul_rsp.prod;
                        default: n_p2 = mul_rsp.prod;
                    endcase
                    if (pi_last) begin
                        n_state = S_COMB;
                    end else begin
                        n_pi    = r_pi + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_COMB: begin
                if (is_arith) begin
                    n_rn    = sum_n;
                    n_rd    = (r_kind == KIND_ADD || r_kind == KIND_SUB) ? r_p2 : r_p1;
                    n_x     = sum_n;
                    n_y     = n_rd;
                    n_sel   = SEL_R;
                    n_state = S_GCD;
                end else begin
                    // sign of the denominator product flips less-than
                    if (r_kind == KIND_EQ) begin
                        n_cmp = (r_p0 == r_p1);
                    end else if (r_p2[INT_WIDTH-1]) begin
                        n_cmp = (r_p0 > r_p1);
                    end else begin
                        n_cmp = (r_p0 < r_p1);
                    end
                    n_rn    = '0;
                    n_rd    = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // load output register once it is free
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_onum   = field_out(r_rn);
                    n_oden   = field_out(r_rd);
                    n_ocmp   = r_cmp;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sel    <= SEL_A;
            r_pi     <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_sel    <= n_sel;
            r_pi     <= n_pi;
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_an   <= n_an;
        r_ad   <= n_ad;
        r_bn   <= n_bn;
        r_bd   <= n_bd;
        r_rn   <= n_rn;
        r_rd   <= n_rd;
        r_x    <= n_x;
        r_y    <= n_y;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_cmp  <= n_cmp;
        r_onum <= n_onum;
        r_oden <= n_oden;
        r_ocmp <= n_ocmp;
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.res_numerator   = r_onum;
    assign o_out.res_denominator = r_oden;
    assign o_out.compare_true    = r_ocmp;

endmodule

// File: rtl/core/rau_div.sv
// Truncating signed divider. Aligns the divisor upwards first, then runs one
// restoring step per quotient bit, so the cost follows log2 of the quotient.
module rau_div import rau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_align, n_align;
    logic              r_fix, n_fix;
    logic              r_done, n_done;
    logic              r_negq, n_negq;
    logic              r_negr, n_negr;
    logic [DIV_KW-1:0] r_k, n_k;
    t_mag              r_rem, n_rem;
    t_mag              r_dvs, n_dvs;
    t_mag              r_quo, n_quo;
    t_mag              dvs_up;
    logic              ge;

    assign dvs_up = {r_dvs[INT_WIDTH-2:0], 1'b0};
    assign ge     = (r_rem >= r_dvs);

    // next-state logic
    always_comb begin
        n_busy  = r_busy;
        n_align = r_align;
        n_fix   = r_fix;
        n_done  = 1'b0;
        n_negq  = r_negq;
        n_negr  = r_negr;
        n_k     = r_k;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_align = 1'b1;
            n_fix   = 1'b0;
            n_k     = '0;
            n_rem   = mag(i_req.dividend);
            n_dvs   = mag(i_req.divisor);
            n_quo   = '0;
            n_negq  = i_req.dividend[INT_WIDTH-1] ^ i_req.divisor[INT_WIDTH-1];
            n_negr  = i_req.dividend[INT_WIDTH-1];
        end else if (r_busy) begin
            if (r_align) begin
                // shift divisor up while it still fits under the dividend
                if (!r_dvs[INT_WIDTH-1] && (dvs_up <= r_rem)) begin
                    n_dvs = dvs_up;
                    n_k   = r_k + 1'b1;
                end else begin
                    n_align = 1'b0;
                end
            end else if (r_fix) begin
                // apply signs: quotient by both, remainder follows dividend
                n_quo  = r_negq ? t_mag'(-r_quo) : r_quo;
                n_rem  = r_negr ? t_mag'(-r_rem) : r_rem;
                n_fix  = 1'b0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                // restoring step
                n_rem = ge ? (r_rem - r_dvs) : r_rem;
                n_quo = {r_quo[INT_WIDTH-2:0], ge};
                if (r_k == '0) begin
                    n_fix = 1'b1;
                end else begin
                    n_dvs = r_dvs >> 1;
                    n_k   = r_k - 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_align <= 1'b0;
            r_fix   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_align <= n_align;
            r_fix   <= n_fix;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_negq <= n_negq;
        r_negr <= n_negr;
        r_k    <= n_k;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quo  <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = t_int'(r_quo);
    assign o_rsp.rem  = t_int'(r_rem);

endmodule

// File: rtl/core/rau_mul.sv
// Wrapping multiplier: one 16-bit digit of b per cycle, low bits kept only.
module rau_mul import rau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [MUL_CW-1:0]           r_cnt, n_cnt;
    t_mag                        r_acc, n_acc;
    t_mag                        r_x, n_x;
    logic [MUL_BP-1:0]           r_y, n_y;
    logic [INT_WIDTH+MUL_DIG-1:0] part;
    logic [INT_WIDTH+MUL_DIG-1:0] x_up;

    assign part = r_x * r_y[MUL_DIG-1:0];
    assign x_up = {r_x, {MUL_DIG{1'b0}}};

    // next-state logic
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_x    = t_mag'(i_req.a);
            n_y    = MUL_BP'(t_mag'(i_req.b));
        end else if (r_busy) begin
            n_acc = r_acc + part[INT_WIDTH-1:0];
            n_x   = x_up[INT_WIDTH-1:0];
            n_y   = r_y >> MUL_DIG;
            if (r_cnt == MUL_CW'(MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = t_int'(r_acc);

endmodule

// File: rtl/core/rau_chk.sv
`include "rational_arithmetic_unit_assert.svh"

// Port-level checks on the rational arithmetic unit
module rau_chk import rau_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_field i_res_num,
    input t_field i_res_den,
    input logic   i_cmp
);

    // a stalled result beat stays and holds its payload
    `RAU_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped")
    `RAU_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_res_num) && $stable(i_res_den) && $stable(i_cmp), "stalled result changed")

    // one item in flight: no new beat straight after acceptance
    `RAU_ASSERT_NEXT(a_busy, i_in_valid && i_in_ready, !i_in_ready, "ready after accepting a beat")

    // a true comparison carries no fraction
    `RAU_ASSERT_NOW(a_cmp_zero, i_out_valid && i_cmp, (i_res_num == '0) && (i_res_den == '0), "comparison with fraction fields set")

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_num   (o_out.res_numerator),
    .i_res_den   (o_out.res_denominator),
    .i_cmp       (o_out.compare_true)
);
